>>> rtl/core/pgbb_pkg.sv
// ----------------------------------------------------------------------------
// pgbb_pkg
// Shared widths, grid size, request codes, register indexes and types for
// the point grid binner.
// ----------------------------------------------------------------------------
package pgbb_pkg;

    localparam int GRID_COLS   = 64;
    localparam int GRID_ROWS   = 64;
    localparam int COORD_W     = 32;
    localparam int VAL_W       = 32;
    localparam int SCALE_W     = 32;
    localparam int CNT_W       = 7;
    localparam int RC_W        = 6;
    localparam int IDX_W       = 12;
    localparam int REQ_W       = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int EPOCH_W     = 8;
    localparam int FIFO_D      = 8;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 176;

    localparam logic [REQ_W-1:0] REQ_BIN   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_XMIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VIEW_YMIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_SCALE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SCALE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MODE  = 3'd6;

    localparam logic [VAL_W-1:0]          ONE_Q16   = 32'h0001_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] xmin;
        logic signed [COORD_W-1:0] ymin;
        logic signed [COORD_W-1:0] xmax;
        logic signed [COORD_W-1:0] ymax;
    } t_box;

    localparam t_box BOX_EMPTY = '{xmin: COORD_MAX, ymin: COORD_MAX,
                                   xmax: COORD_MIN, ymax: COORD_MIN};

    typedef struct packed {
        logic [IDX_W-1:0] cell_index;
        logic             in_view;
        logic [VAL_W-1:0] cell_value;
        logic             cell_written;
        t_box             box;
    } t_result;

endpackage

>>> rtl/core/point_grid_binner_bbox.sv
// ----------------------------------------------------------------------------
// point_grid_binner_bbox
// Bins Q16.16 points into a dense occupancy grid, serves cell reads and
// clears, and tracks a running bounding box of all binned points.
//
// Input stream: tuser carries the request kind (bin, read, clear), tdata
// the point and the read address. Every beat gives exactly one result beat
// on the output stream, in order. The user must write configuration
// through the plain write port only while the block is idle; the block
// does not enforce this. One beat is taken every cycle while credits
// remain and no tag pass runs; the grid memory has one write and one read
// port, and each beat uses each port at most once. Results collect in an
// 8-deep output queue; input credits keep the queue from overflowing, so
// a stalled receiver only stops input once 8 beats are pending. Written
// flags are epoch tags stored beside each cell; a clear bumps the epoch.
// After reset, and on every 255th clear, a pass rewrites the tags of all
// GRID_COLS*GRID_ROWS cells, one per cycle (4096 cells at the default
// size); input is held off during the pass.
// ----------------------------------------------------------------------------
module point_grid_binner_bbox
    import pgbb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // config write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [SCALE_W-1:0]     i_cfg_wdata,
    // input beats
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // pt_x, pt_y, pt_value, read_col, read_row
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]       i_s_axis_tuser,
    // result beats
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // cell_index, in_view, cell_value, cell_written,
    // box_xmin, box_ymin, box_xmax, box_ymax
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata
);

    localparam int CELLS  = GRID_COLS * GRID_ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MEM_W  = EPOCH_W + VAL_W;
    localparam int LIN_W  = 2 * CNT_W;
    localparam int PTR_W  = $clog2(FIFO_D);
    localparam int CRD_W  = $clog2(FIFO_D + 1);

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [VAL_W-1:0]   val;
        logic [RC_W-1:0]    rc;
        logic [RC_W-1:0]    rr;
        logic [EPOCH_W-1:0] ep;
        t_box               box;
    } t_carry;

    // configuration
    logic signed [COORD_W-1:0] r_view_xmin;
    logic signed [COORD_W-1:0] r_view_ymin;
    logic [SCALE_W-1:0]        r_col_scale;
    logic [SCALE_W-1:0]        r_row_scale;
    logic [CNT_W-1:0]          r_cols_in_use;
    logic [CNT_W-1:0]          r_rows_in_use;
    logic                      r_value_mode;
    logic [CNT_W-1:0]          cols;
    logic [CNT_W-1:0]          rows;

    // control
    logic                      s_acc;
    logic                      m_acc;
    logic [EPOCH_W-1:0]        r_epoch;
    logic                      r_swp;
    logic [ADDR_W-1:0]         r_swp_addr;
    logic [CRD_W-1:0]          r_cnt;
    logic [CRD_W-1:0]          n_cnt;
    logic                      busy;

    // pipeline
    logic                      r1_v, r2_v, r3_v, r4_v, r5_v, r6_v;
    logic [REQ_W-1:0]          r1_req;
    logic signed [COORD_W-1:0] r1_x;
    logic signed [COORD_W-1:0] r1_y;
    logic [VAL_W-1:0]          r1_val;
    logic [RC_W-1:0]           r1_rc;
    logic [RC_W-1:0]           r1_rr;
    logic [EPOCH_W-1:0]        r1_ep;
    t_box                      r_box;
    t_box                      n_box;
    t_carry                    r2_c, r3_c, r4_c;

    logic [CNT_W-1:0]          ax_col, ax_row;
    logic                      ax_col_ok, ax_row_ok;
    logic [CNT_W-1:0]          s4_col, s4_row;
    logic                      s4_ok;
    logic [LIN_W-1:0]          s4_lin;

    logic [REQ_W-1:0]          r5_req;
    logic                      r5_ok;
    logic [LIN_W-1:0]          r5_lin;
    logic [VAL_W-1:0]          r5_val;
    logic [EPOCH_W-1:0]        r5_ep;
    t_box                      r5_box;

    logic [REQ_W-1:0]          r6_req;
    logic                      r6_ok;
    logic [LIN_W-1:0]          r6_lin;
    logic [EPOCH_W-1:0]        r6_ep;
    t_box                      r6_box;
    logic [MEM_W-1:0]          r6_rd;

    // grid memory
    logic [MEM_W-1:0]          grid_mem [CELLS];
    logic [ADDR_W-1:0]         rd_addr;
    logic                      item_we;
    logic                      swp_we;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_wa;
    logic [MEM_W-1:0]          mem_wd;

    // output queue
    t_result                   res;
    t_result                   r_fifo [FIFO_D];
    logic [PTR_W-1:0]          r_wp, r_rp;
    logic [CRD_W-1:0]          r_fcnt;
    t_result                   head;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_xmin   <= '0;
            r_view_ymin   <= '0;
            r_col_scale   <= ONE_Q16;
            r_row_scale   <= ONE_Q16;
            r_cols_in_use <= CNT_W'(64);
            r_rows_in_use <= CNT_W'(64);
            r_value_mode  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VIEW_XMIN:   r_view_xmin   <= i_cfg_wdata;
                CFG_VIEW_YMIN:   r_view_ymin   <= i_cfg_wdata;
                CFG_COL_SCALE:   r_col_scale   <= i_cfg_wdata;
                CFG_ROW_SCALE:   r_row_scale   <= i_cfg_wdata;
                CFG_COLS_IN_USE: r_cols_in_use <= i_cfg_wdata[CNT_W-1:0];
                CFG_ROWS_IN_USE: r_rows_in_use <= i_cfg_wdata[CNT_W-1:0];
                CFG_VALUE_MODE:  r_value_mode  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign cols = (32'(r_cols_in_use) > 32'(GRID_COLS)) ? CNT_W'(GRID_COLS) : r_cols_in_use;
    assign rows = (32'(r_rows_in_use) > 32'(GRID_ROWS)) ? CNT_W'(GRID_ROWS) : r_rows_in_use;

    // ---------------- handshake, credits, epoch ----------------
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc           = o_m_axis_tvalid && i_m_axis_tready;
    assign o_s_axis_tready = !r_swp && (r_cnt < CRD_W'(FIFO_D));
    assign busy            = r1_v || r2_v || r3_v || r4_v || r5_v;
    assign swp_we          = r_swp && !busy;

    always_comb begin
        n_cnt = r_cnt;
        if (s_acc && !m_acc) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!s_acc && m_acc) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_epoch    <= EPOCH_W'(1);
            r_swp      <= 1'b1;
            r_swp_addr <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (s_acc && (i_s_axis_tuser == REQ_CLEAR)) begin
                if (r_epoch == '1) begin
                    r_epoch    <= EPOCH_W'(1);
                    r_swp      <= 1'b1;
                    r_swp_addr <= '0;
                end else begin
                    r_epoch <= r_epoch + 1'b1;
                end
            end
            if (swp_we) begin
                if (r_swp_addr == ADDR_W'(CELLS - 1)) begin
                    r_swp <= 1'b0;
                end else begin
                    r_swp_addr <= r_swp_addr + 1'b1;
                end
            end
        end
    end

    // ---------------- stage 1: input register, bounding box ----------------
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r1_req <= i_s_axis_tuser;
            r1_x   <= i_s_axis_tdata[31:0];
            r1_y   <= i_s_axis_tdata[63:32];
            r1_val <= i_s_axis_tdata[95:64];
            r1_rc  <= i_s_axis_tdata[101:96];
            r1_rr  <= i_s_axis_tdata[107:102];
            r1_ep  <= r_epoch;
        end
    end

    always_comb begin
        n_box = r_box;
        if (r1_v) begin
            case (r1_req)
                REQ_CLEAR: n_box = BOX_EMPTY;
                REQ_BIN: begin
                    if ($signed(r1_x) < $signed(r_box.xmin)) n_box.xmin = r1_x;
                    if ($signed(r1_y) < $signed(r_box.ymin)) n_box.ymin = r1_y;
                    if ($signed(r1_x) > $signed(r_box.xmax)) n_box.xmax = r1_x;
                    if ($signed(r1_y) > $signed(r_box.ymax)) n_box.ymax = r1_y;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box <= BOX_EMPTY;
            r1_v  <= 1'b0;
            r2_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r6_v  <= 1'b0;
        end else begin
            r_box <= n_box;
            r1_v  <= s_acc;
            r2_v  <= r1_v;
            r3_v  <= r2_v;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r6_v  <= r5_v;
        end
    end

    // ---------------- stages 2-4: axis mapping ----------------
    pgbb_axis u_axis_x (
        .i_clk    (i_clk),
        .i_coord  (r1_x),
        .i_origin (r_view_xmin),
        .i_scale  (r_col_scale),
        .i_cnt    (cols),
        .o_pos    (ax_col),
        .o_ok     (ax_col_ok)
    );

    pgbb_axis u_axis_y (
        .i_clk    (i_clk),
        .i_coord  (r1_y),
        .i_origin (r_view_ymin),
        .i_scale  (r_row_scale),
        .i_cnt    (rows),
        .o_pos    (ax_row),
        .o_ok     (ax_row_ok)
    );

    always_ff @(posedge i_clk) begin
        r2_c <= '{req: r1_req, val: r1_val, rc: r1_rc, rr: r1_rr, ep: r1_ep, box: n_box};
        r3_c <= r2_c;
        r4_c <= r3_c;
    end

    // ---------------- stage 4: linear index ----------------
    always_comb begin
        s4_col = ax_col;
        s4_row = ax_row;
        s4_ok  = 1'b0;
        case (r4_c.req)
            REQ_BIN: s4_ok = ax_col_ok && ax_row_ok;
            REQ_READ: begin
                s4_col = CNT_W'(r4_c.rc);
                s4_row = CNT_W'(r4_c.rr);
                s4_ok  = (CNT_W'(r4_c.rc) < cols) && (CNT_W'(r4_c.rr) < rows);
            end
            default: ;
        endcase
    end

    assign s4_lin = LIN_W'(s4_row) * LIN_W'(cols) + LIN_W'(s4_col);

    always_ff @(posedge i_clk) begin
        r5_req <= r4_c.req;
        r5_ok  <= s4_ok && (32'(s4_lin) < 32'(CELLS));
        r5_lin <= s4_lin;
        r5_val <= r4_c.val;
        r5_ep  <= r4_c.ep;
        r5_box <= r4_c.box;
    end

    // ---------------- stage 5: grid memory ----------------
    assign rd_addr = ADDR_W'(r5_lin);
    assign item_we = r5_v && (r5_req == REQ_BIN) && r5_ok;
    assign mem_we  = item_we || swp_we;
    assign mem_wa  = swp_we ? r_swp_addr : rd_addr;
    assign mem_wd  = swp_we ? '0 : {r5_ep, (r_value_mode ? r5_val : ONE_Q16)};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            grid_mem[mem_wa] <= mem_wd;
        end
        r6_rd <= grid_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r6_req <= r5_req;
        r6_ok  <= r5_ok;
        r6_lin <= r5_lin;
        r6_ep  <= r5_ep;
        r6_box <= r5_box;
    end

    // ---------------- stage 6: result ----------------
    always_comb begin
        res              = '0;
        res.box          = r6_box;
        res.in_view      = r6_ok;
        res.cell_index   = r6_ok ? r6_lin[IDX_W-1:0] : '0;
        res.cell_written = (r6_req == REQ_READ) && r6_ok
                        && (r6_rd[MEM_W-1 -: EPOCH_W] == r6_ep);
        res.cell_value   = res.cell_written ? r6_rd[VAL_W-1:0] : '0;
    end

    // ---------------- output queue ----------------
    always_ff @(posedge i_clk) begin
        if (r6_v) begin
            r_fifo[r_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (r6_v) r_wp <= r_wp + 1'b1;
            if (m_acc) r_rp <= r_rp + 1'b1;
            if (r6_v && !m_acc) begin
                r_fcnt <= r_fcnt + 1'b1;
            end else if (!r6_v && m_acc) begin
                r_fcnt <= r_fcnt - 1'b1;
            end
        end
    end

    assign head            = r_fifo[r_rp];
    assign o_m_axis_tvalid = (r_fcnt != '0);
    assign o_m_axis_tdata  = {2'b00,
                              head.box.ymax, head.box.xmax,
                              head.box.ymin, head.box.xmin,
                              head.cell_written, head.cell_value,
                              head.in_view, head.cell_index};

    // ---------------- assertions ----------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CRD_W'(FIFO_D))
        else $error("credit count above queue depth");

    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(swp_we && item_we))
        else $error("tag sweep collides with a cell write");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r6_v |-> (r_fcnt < CRD_W'(FIFO_D)) || m_acc)
        else $error("result queue overflow");

    a_queue_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_cnt)
        else $error("queued results exceed outstanding credits");

endmodule

>>> rtl/core/pgbb_axis.sv
// ----------------------------------------------------------------------------
// pgbb_axis
// Three-stage coordinate to grid position mapper: offset from the view
// origin, magnitude times Q16.16 scale, truncation toward zero, range check.
// ----------------------------------------------------------------------------
module pgbb_axis
    import pgbb_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [COORD_W-1:0] i_coord,
    input  logic signed [COORD_W-1:0] i_origin,
    input  logic [SCALE_W-1:0]        i_scale,
    input  logic [CNT_W-1:0]          i_cnt,
    output logic [CNT_W-1:0]          o_pos,
    output logic                      o_ok
);

    logic signed [COORD_W:0]  diff;
    logic [COORD_W:0]         mag;
    logic [SCALE_W:0]         sum;
    logic                     neg_nz;

    logic [COORD_W:0]         r_mag;
    logic                     r_neg_a;
    logic [2*SCALE_W-1:0]     r_prod;
    logic                     r_hi;
    logic                     r_neg_b;

    assign diff = {i_coord[COORD_W-1], i_coord} - {i_origin[COORD_W-1], i_origin};
    assign mag  = diff[COORD_W] ? (~diff + 1'b1) : diff;

    assign sum    = {1'b0, r_prod[2*SCALE_W-1:SCALE_W]}
                  + (r_hi ? {1'b0, i_scale} : '0);
    assign neg_nz = r_neg_b && (sum != '0);

    always_ff @(posedge i_clk) begin
        r_mag   <= mag;
        r_neg_a <= diff[COORD_W];
        r_prod  <= r_mag[COORD_W-1:0] * i_scale;
        r_hi    <= r_mag[COORD_W];
        r_neg_b <= r_neg_a;
        o_pos   <= sum[CNT_W-1:0];
        o_ok    <= !neg_nz && (sum < (SCALE_W+1)'(i_cnt));
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_grid_binner_bbox. A queue-fed driver sends
// bin, read, clear and unknown requests while a shadow copy of the grid, the
// written flags, the bounding box and the registers predicts every result
// beat. Several register settings follow, the extremes among them, with a
// long run of clears to wrap the clear epoch. The sender and the receiver
// stall at random in changing proportions.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pgbb_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam int NCOLS = 64;
    localparam int NROWS = 64;
    localparam int NCELLS = NCOLS * NROWS;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [VAL_W-1:0]          v;
        logic [RC_W-1:0]           rc;
        logic [RC_W-1:0]           rr;
    } t_req;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx = '0;
    logic [SCALE_W-1:0]     i_cfg_wdata = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [REQ_W-1:0]       i_s_axis_tuser = '0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // shadow of the block
    logic signed [COORD_W-1:0] cfg_vx, cfg_vy;
    logic [SCALE_W-1:0]        cfg_cs, cfg_rs;
    logic [CNT_W-1:0]          cfg_cols, cfg_rows;
    logic                      cfg_mode;
    logic [VAL_W-1:0]          cell_val [NCELLS];
    bit                        cell_set [NCELLS];
    t_box                      box;

    t_req    req_queue [$];
    t_result due_results [$];
    t_req    on_bus;
    t_req    next_req;
    int      idle_mode = 0;
    int      mismatches = 0;

    point_grid_binner_bbox u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned eff_count(logic [CNT_W-1:0] n, int unsigned lim);
        return (n > lim) ? lim : n;
    endfunction

    // pixel position along one axis, -1 when a whole pixel or more below the origin
    function automatic longint axis_bin(logic signed [COORD_W-1:0] p,
                                        logic signed [COORD_W-1:0] origin,
                                        logic [SCALE_W-1:0] scale);
        longint d;
        longint unsigned mag, prod;
        d = longint'(p) - longint'(origin);
        mag = (d < 0) ? longint'(-d) : longint'(d);
        prod = mag * {32'b0, scale};
        if (d < 0 && prod[63:32] != 0) return -1;
        return longint'({32'b0, prod[63:32]});
    endfunction

    function automatic t_result grid_response(t_req rq);
        t_result res;
        int unsigned cols, rows, k;
        longint col, row;
        cols = eff_count(cfg_cols, NCOLS);
        rows = eff_count(cfg_rows, NROWS);
        res = '0;
        case (rq.kind)
            REQ_BIN: begin
                col = axis_bin(rq.x, cfg_vx, cfg_cs);
                row = axis_bin(rq.y, cfg_vy, cfg_rs);
                if (rq.x < $signed(box.xmin)) box.xmin = rq.x;
                if (rq.y < $signed(box.ymin)) box.ymin = rq.y;
                if (rq.x > $signed(box.xmax)) box.xmax = rq.x;
                if (rq.y > $signed(box.ymax)) box.ymax = rq.y;
                if (col >= 0 && row >= 0 && col < longint'(cols) && row < longint'(rows)) begin
                    k = int'(row) * cols + int'(col);
                    cell_val[k] = cfg_mode ? rq.v : ONE_Q16;
                    cell_set[k] = 1'b1;
                    res.cell_index = k[IDX_W-1:0];
                    res.in_view = 1'b1;
                end
            end
            REQ_READ: begin
                if (rq.rc < cols && rq.rr < rows) begin
                    k = rq.rr * cols + rq.rc;
                    res.cell_index = k[IDX_W-1:0];
                    res.in_view = 1'b1;
                    if (cell_set[k]) begin
                        res.cell_written = 1'b1;
                        res.cell_value = cell_val[k];
                    end
                end
            end
            REQ_CLEAR: begin
                foreach (cell_set[i]) cell_set[i] = 1'b0;
                box = BOX_EMPTY;
            end
            default: ;
        endcase
        res.box = box;
        return res;
    endfunction

    // coordinate mostly inside the view along one axis, some just below it
    function automatic logic signed [COORD_W-1:0] near_edge(logic signed [COORD_W-1:0] origin,
                                                           logic [SCALE_W-1:0] scale,
                                                           logic [CNT_W-1:0] count);
        longint unsigned span;
        logic [31:0] span32, pixel;
        int unsigned cnt, pick;
        cnt = eff_count(count, NCOLS);
        if (cnt == 0) cnt = 1;
        if (scale == 0) span = 64'hFFFF_FFFF;
        else span = (longint'(cnt) << 32) / {32'b0, scale};
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        span32 = span[31:0];
        pixel = span32 / cnt;
        pick = $urandom_range(0, 99);
        if (pick < 75) return origin + 32'($urandom_range(0, span32));
        if (pick < 88) return origin - 32'($urandom_range(0, pixel + 2));
        return $urandom;
    endfunction

    function automatic logic [RC_W-1:0] pick_addr(logic [CNT_W-1:0] count);
        int unsigned cnt;
        cnt = eff_count(count, NCOLS);
        if (cnt != 0 && $urandom_range(0, 99) < 70) return RC_W'($urandom_range(0, cnt - 1));
        return RC_W'($urandom_range(0, 63));
    endfunction

    function automatic t_req make_req(logic [REQ_W-1:0] kind, logic [31:0] x, logic [31:0] y,
                                      logic [31:0] v, logic [RC_W-1:0] rc,
                                      logic [RC_W-1:0] rr);
        t_req rq;
        rq.kind = kind;
        rq.x = x;
        rq.y = y;
        rq.v = v;
        rq.rc = rc;
        rq.rr = rr;
        return rq;
    endfunction

    function automatic t_req random_req();
        t_req rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        rq = make_req(REQ_BIN, near_edge(cfg_vx, cfg_cs, cfg_cols),
                      near_edge(cfg_vy, cfg_rs, cfg_rows), $urandom,
                      pick_addr(cfg_cols), pick_addr(cfg_rows));
        if (pick >= 95) rq.kind = REQ_UNKNOWN;
        else if (pick >= 90) rq.kind = REQ_CLEAR;
        else if (pick >= 60) rq.kind = REQ_READ;
        return rq;
    endfunction

    function automatic int unsigned send_idle_pct();
        return (idle_mode == 0) ? 10 : (idle_mode == 1) ? 62 : 0;
    endfunction

    function automatic int unsigned recv_idle_pct();
        return (idle_mode == 0) ? 62 : (idle_mode == 1) ? 10 : 0;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (i_s_axis_tvalid) due_results.push_back(grid_response(on_bus));
            if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
                next_req = req_queue.pop_front();
                on_bus <= next_req;
                i_s_axis_tdata <= {4'b0, next_req.rr, next_req.rc, next_req.v,
                                   next_req.y, next_req.x};
                i_s_axis_tuser <= next_req.kind;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    task automatic flag_field(string name, logic [31:0] want, logic [31:0] got);
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        mismatches++;
    endtask

    task automatic check_beat(logic [OUT_TDATA_W-1:0] d);
        t_result want;
        if (due_results.size() == 0) begin
            $display("%0t: beat with nothing expected, expected none got %h", $time, d);
            mismatches++;
            return;
        end
        want = due_results.pop_front();
        if (d[11:0] !== want.cell_index)
            flag_field("cell_index", 32'(want.cell_index), 32'(d[11:0]));
        if (d[12] !== want.in_view)
            flag_field("in_view", 32'(want.in_view), 32'(d[12]));
        if (d[44:13] !== want.cell_value)
            flag_field("cell_value", want.cell_value, d[44:13]);
        if (d[45] !== want.cell_written)
            flag_field("cell_written", 32'(want.cell_written), 32'(d[45]));
        if (d[77:46] !== want.box.xmin) flag_field("box_xmin", want.box.xmin, d[77:46]);
        if (d[109:78] !== want.box.ymin) flag_field("box_ymin", want.box.ymin, d[109:78]);
        if (d[141:110] !== want.box.xmax) flag_field("box_xmax", want.box.xmax, d[141:110]);
        if (d[173:142] !== want.box.ymax) flag_field("box_ymax", want.box.ymax, d[173:142]);
    endtask

    // monitor and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) check_beat(o_m_axis_tdata);
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct());
        end
    end

    task automatic wait_drained();
        while (req_queue.size() != 0 || i_s_axis_tvalid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SCALE_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_VIEW_XMIN:   cfg_vx = data;
            CFG_VIEW_YMIN:   cfg_vy = data;
            CFG_COL_SCALE:   cfg_cs = data;
            CFG_ROW_SCALE:   cfg_rs = data;
            CFG_COLS_IN_USE: cfg_cols = data[CNT_W-1:0];
            CFG_ROWS_IN_USE: cfg_rows = data[CNT_W-1:0];
            CFG_VALUE_MODE:  cfg_mode = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(logic [31:0] vx, logic [31:0] vy, logic [31:0] cs,
                                 logic [31:0] rs, logic [CNT_W-1:0] cols,
                                 logic [CNT_W-1:0] rows, logic mode);
        wait_drained();
        while (!o_s_axis_tready) @(posedge i_clk);
        write_reg(CFG_VIEW_XMIN, vx);
        write_reg(CFG_VIEW_YMIN, vy);
        write_reg(CFG_COL_SCALE, cs);
        write_reg(CFG_ROW_SCALE, rs);
        write_reg(CFG_COLS_IN_USE, 32'(cols));
        write_reg(CFG_ROWS_IN_USE, 32'(rows));
        write_reg(CFG_VALUE_MODE, 32'(mode));
    endtask

    task automatic push_random(int n);
        for (int i = 0; i < n; i++) req_queue.push_back(random_req());
    endtask

    task automatic push_read(logic [RC_W-1:0] c, logic [RC_W-1:0] r);
        req_queue.push_back(make_req(REQ_READ, $urandom, $urandom, $urandom, c, r));
    endtask

    task automatic push_bin(logic [31:0] x, logic [31:0] y);
        req_queue.push_back(make_req(REQ_BIN, x, y, $urandom, RC_W'($urandom),
                                     RC_W'($urandom)));
    endtask

    initial begin
        t_req rq;
        cfg_vx = '0;
        cfg_vy = '0;
        cfg_cs = ONE_Q16;
        cfg_rs = ONE_Q16;
        cfg_cols = 7'd64;
        cfg_rows = 7'd64;
        cfg_mode = 1'b0;
        foreach (cell_set[i]) cell_set[i] = 1'b0;
        foreach (cell_val[i]) cell_val[i] = '0;
        box = BOX_EMPTY;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apply_setting(0, 0, ONE_Q16, ONE_Q16, 64, 64, 1'b0);
        push_read(6'd63, 6'd63);
        push_read(6'd0, 6'd0);
        req_queue.push_back(make_req(REQ_CLEAR, $urandom, $urandom, $urandom, 0, 0));
        push_read(6'd5, 6'd3);
        req_queue.push_back(make_req(REQ_BIN, COORD_MAX, COORD_MAX, '1, '1, '1));
        req_queue.push_back(make_req(REQ_BIN, COORD_MIN, COORD_MIN, '0, '0, '0));
        push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF);        // just below origin, still cell 0
        push_bin(32'hFFFF_0000, 32'h0000_8000);        // one full pixel left: out
        push_bin(32'h003F_FFFF, 32'h003F_FFFF);        // last cell
        push_bin(32'h0040_0000, 32'h0000_0000);        // one column past
        push_bin(32'h0000_0000, 32'h0040_0000);        // one row past
        push_read(6'd0, 6'd0);
        push_read(6'd63, 6'd63);
        push_read(6'd0, 6'd63);
        req_queue.push_back(make_req(REQ_UNKNOWN, '1, '1, '1, '1, '1));
        push_bin(32'h0003_0000, 32'h0007_0000);
        push_read(6'd3, 6'd7);

        idle_mode = 0;
        apply_setting(32'hFFF6_0000, 32'h0005_8000, 32'h0000_4000, 32'h0002_8000,
                      40, 17, 1'b1);
        push_read(6'd39, 6'd16);
        push_read(6'd40, 6'd0);
        push_read(6'd0, 6'd17);
        push_random(110);
        apply_setting(COORD_MIN, COORD_MAX, '1, '1, 1, 1, 1'b1);
        push_random(110);

        idle_mode = 1;
        apply_setting(COORD_MAX, COORD_MIN, 0, 0, 64, 64, 1'b0);
        push_random(55);
        wait_drained();
        push_random(55);
        apply_setting($urandom, $urandom, $urandom_range(32'h100, 32'h10_0000),
                      $urandom_range(32'h100, 32'h10_0000), CNT_W'($urandom_range(1, 64)),
                      CNT_W'($urandom_range(1, 64)), 1'b1);
        push_random(110);

        idle_mode = 2;
        apply_setting(0, 0, ONE_Q16, ONE_Q16, 127, 0, 1'b0);
        push_random(110);
        apply_setting(32'hFFE0_0000, 32'hFFE0_0000, ONE_Q16, ONE_Q16, 64, 100, 1'b1);
        push_random(60);
        // long run of clears to wrap the clear epoch
        for (int j = 0; j < 260; j++) begin
            req_queue.push_back(make_req(REQ_CLEAR, $urandom, $urandom, $urandom,
                                         RC_W'($urandom), RC_W'($urandom)));
            if (j % 16 == 0) begin
                rq = random_req();
                rq.kind = REQ_BIN;
                req_queue.push_back(rq);
                push_read(rq.rc, rq.rr);
            end
        end
        push_random(60);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
